FILE: src/itoa_pkg.sv
// shared types, codes and constants of the integer to ascii formatter
package itoa_pkg;

  // word size for binary clamp and default hex length
  localparam int WORD_BITS = 32;

  // stream widths
  localparam int IN_BITS  = 40;
  localparam int OUT_BITS = 8;

  // radix select codes
  localparam logic [1:0] OP_DEC = 2'd0;
  localparam logic [1:0] OP_BIN = 2'd1;
  localparam logic [1:0] OP_HEX = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // character source select
  localparam logic [2:0] CH_ZERO  = 3'd0;
  localparam logic [2:0] CH_RADIX = 3'd1;
  localparam logic [2:0] CH_MINUS = 3'd2;
  localparam logic [2:0] CH_DEC   = 3'd3;
  localparam logic [2:0] CH_DIGIT = 3'd4;

  // ascii codes
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_ALPHA = 8'd55;
  localparam logic [7:0] ASCII_B     = 8'h62;
  localparam logic [7:0] ASCII_X     = 8'h78;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // reciprocal of ten, exact for 32-bit values with a 35-bit shift
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  // digit counts at the start of a binary or hex conversion
  localparam logic [5:0] BIN_DIGITS = 6'd32;
  localparam logic [5:0] HEX_DIGITS = 6'd8;
  localparam logic [5:0] HEX_DEFAULT = 6'((WORD_BITS + 3) / 4);

  // commands from the controller
  typedef struct packed {
    logic       load;
    logic       mul;
    logic       div_step;
    logic       cnt_dec;
    logic       pop;
    logic       emit;
    logic [2:0] emit_sel;
    logic       emit_last;
  } ctrl_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic [1:0] new_op;
    logic       neg;
    logic       quot_zero;
    logic       nd_last;
    logic       cnt_last;
    logic       skip_ok;
    logic       out_free;
  } ctrl_sts_t;

endpackage

FILE: src/itoa_dp.sv
// datapath: operand registers, divide-by-ten step, digit stack and output register
module itoa_dp import itoa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [IN_BITS-1:0]  s_tdata,
  input  ctrl_cmd_t           cmd,
  output ctrl_sts_t           sts,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [OUT_BITS-1:0] m_tdata,
  output logic                m_tlast
);

  logic [1:0]  op_r;
  logic [31:0] u;
  logic [5:0]  floor_cnt;
  logic [31:0] mag;
  logic [63:0] prod;
  logic [39:0] digs;
  logic [3:0]  nd;
  logic [5:0]  cnt;

  // input field unpack
  logic [1:0]  in_op;
  logic [31:0] in_value;
  logic [5:0]  in_pw;
  logic [5:0]  in_floor;
  logic [5:0]  bin_w;

  assign in_op    = s_tdata[1:0];
  assign in_value = s_tdata[33:2];
  assign in_pw    = s_tdata[39:34];

  // minimum digit count for the padding
  always_comb begin
    bin_w = (in_pw > 6'(WORD_BITS)) ? 6'(WORD_BITS) : in_pw;
    if (bin_w == 6'd0) begin
      bin_w = 6'd1;
    end
    if (in_op == OP_BIN) begin
      in_floor = bin_w;
    end else begin
      case (in_pw)
        6'd8:    in_floor = 6'd2;
        6'd16:   in_floor = 6'd4;
        6'd32:   in_floor = 6'd8;
        default: in_floor = HEX_DEFAULT;
      endcase
    end
  end

  // divide-by-ten step on the registered product
  logic [28:0] quot;
  logic [31:0] rem;
  assign quot = prod[63:DIV10_SHIFT];
  assign rem  = mag - {quot, 3'b000} - 32'({quot, 1'b0});

  // digit selection for binary and hex
  logic [4:0] bit_idx;
  logic [2:0] nib_idx;
  logic [4:0] nib_sh;
  logic [3:0] nib;
  logic       bit_hi;
  logic       bit_nx;
  logic       nib_lowb;
  logic       is_neg;

  assign is_neg   = u[31];
  assign bit_idx  = 5'(cnt - 6'd1);
  assign bit_hi   = u[bit_idx];
  assign bit_nx   = u[5'(bit_idx - 5'd1)];
  assign nib_idx  = 3'(cnt - 6'd1);
  assign nib_sh   = {nib_idx, 2'b00};
  assign nib      = 4'(u >> nib_sh);
  assign nib_lowb = u[5'(nib_sh - 5'd1)];

  // leading digit is redundant and the padding allows dropping it
  logic skip_ok;
  always_comb begin
    if (cnt <= floor_cnt) begin
      skip_ok = 1'b0;
    end else if (op_r == OP_BIN) begin
      skip_ok = is_neg ? (bit_hi & bit_nx) : !bit_hi;
    end else begin
      skip_ok = is_neg ? ((nib == 4'hF) && nib_lowb) : (nib == 4'h0);
    end
  end

  // character for the current emit
  logic [7:0] char_next;
  always_comb begin
    case (cmd.emit_sel)
      CH_ZERO:  char_next = ASCII_ZERO;
      CH_RADIX: char_next = (op_r == OP_BIN) ? ASCII_B : ASCII_X;
      CH_MINUS: char_next = ASCII_MINUS;
      CH_DEC:   char_next = ASCII_ZERO + 8'(digs[3:0]);
      CH_DIGIT: begin
        if (op_r == OP_BIN) begin
          char_next = ASCII_ZERO + 8'(bit_hi);
        end else if (nib >= 4'd10) begin
          char_next = ASCII_ALPHA + 8'(nib);
        end else begin
          char_next = ASCII_ZERO + 8'(nib);
        end
      end
      default:  char_next = ASCII_ZERO;
    endcase
  end

  // operand and conversion registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      u         <= in_value;
      floor_cnt <= in_floor;
      mag       <= in_value[31] ? (32'd0 - in_value) : in_value;
      nd        <= 4'd0;
      cnt       <= (in_op == OP_BIN) ? BIN_DIGITS : HEX_DIGITS;
    end else begin
      if (cmd.mul) begin
        prod <= 64'(mag) * 64'(DIV10_RECIP);
      end
      if (cmd.div_step) begin
        digs <= {digs[35:0], rem[3:0]};
        mag  <= 32'(quot);
        nd   <= nd + 4'd1;
      end
      if (cmd.pop) begin
        digs <= {4'd0, digs[39:4]};
        nd   <= nd - 4'd1;
      end
      if (cmd.cnt_dec) begin
        cnt <= cnt - 6'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= char_next;
      m_tlast <= cmd.emit_last;
    end
  end

  // status
  assign sts.new_op    = in_op;
  assign sts.neg       = is_neg;
  assign sts.quot_zero = (quot == 29'd0);
  assign sts.nd_last   = (nd == 4'd1);
  assign sts.cnt_last  = (cnt == 6'd1);
  assign sts.skip_ok   = skip_ok;
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule

FILE: src/itoa_ctrl.sv
// controller: sequences conversion steps and character transfers
module itoa_ctrl import itoa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DMUL  = 4'd1;
  localparam logic [3:0] S_DREM  = 4'd2;
  localparam logic [3:0] S_DSIGN = 4'd3;
  localparam logic [3:0] S_DDIG  = 4'd4;
  localparam logic [3:0] S_SKIP  = 4'd5;
  localparam logic [3:0] S_PFX0  = 4'd6;
  localparam logic [3:0] S_PFX1  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit_sel = CH_ZERO;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          case (sts.new_op)
            OP_DEC:  state_next = S_DMUL;
            OP_BIN:  state_next = S_SKIP;
            OP_HEX:  state_next = S_SKIP;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_DMUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DREM;
      end
      S_DREM: begin
        cmd.div_step = 1'b1;
        state_next   = sts.quot_zero ? S_DSIGN : S_DMUL;
      end
      S_DSIGN: begin
        if (!sts.neg) begin
          state_next = S_DDIG;
        end else if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = CH_MINUS;
          state_next   = S_DDIG;
        end
      end
      S_DDIG: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = CH_DEC;
          cmd.emit_last = sts.nd_last;
          cmd.pop       = 1'b1;
          if (sts.nd_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_SKIP: begin
        if (sts.skip_ok) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          state_next = S_PFX0;
        end
      end
      S_PFX0: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = CH_ZERO;
          state_next   = S_PFX1;
        end
      end
      S_PFX1: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = CH_RADIX;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = CH_DIGIT;
          cmd.emit_last = sts.cnt_last;
          cmd.cnt_dec   = 1'b1;
          if (sts.cnt_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/int_to_ascii_radix_format_top.sv
// top level of the integer to ascii formatter
//
//  channel   dir  payload                                    end marker
//  s_*       in   tdata: op[1:0] value[33:2] pad_width[39:34]  -
//  m_*       out  tdata: char_code[7:0]                       tlast = last
//
// one item at a time; input is taken only while the controller is idle
// decimal: a reciprocal multiply step, then a remainder step, for each digit, then
// the sign slot, then the digits; binary/hex: a skip step per dropped leading digit
// plus one to stop, then the 0 and radix prefix, then the digit characters;
// radix code 3 is accepted with no output
// synchronous reset clears the controller and output valid; a stall pauses the sequence
module int_to_ascii_radix_format_top import itoa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_BITS-1:0]  s_tdata,   // op[1:0], value[33:2], pad_width[39:34]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata,   // char_code[7:0]
  output logic                m_tlast
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer
  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // conversion datapath and output register
  itoa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the integer to ascii formatter
`timescale 1ns / 1ps

module testbench import itoa_pkg::*;;

  // one expected character of the formatted text
  typedef struct packed {
    int unsigned item;
    logic [7:0]  code;
    logic        last;
  } text_char_t;

  // receiver stall styles
  typedef enum int unsigned {RX_FREE, RX_COIN, RX_BURSTY, RX_TOGGLE} rx_mode_t;

  // formats each accepted item and checks the characters that come back
  class char_scoreboard;
    text_char_t  pending_chars[$];
    int unsigned error_count;
    int unsigned item_count;

    function new();
      error_count = 0;
      item_count  = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
    endtask

    // shortest form of the pattern: magnitude bits, or two's complement with sign
    function int unsigned sig_bits(logic [31:0] word);
      logic [31:0] bits;
      int unsigned n;
      bits = word[31] ? ~word : word;
      n = 0;
      for (int i = 31; i >= 0; i--) begin
        if (bits[i] && n == 0) n = i + 1;
      end
      if (word[31]) n = n + 1;
      else if (n == 0) n = 1;
      return n;
    endfunction

    // expected characters for one input item
    function void note_item(logic [1:0] op, logic [31:0] word, logic [5:0] pad_width);
      logic [7:0]  text[$];
      logic [31:0] mag;
      logic [3:0]  nib;
      int unsigned ndig;
      int unsigned width;
      text_char_t  ch;
      case (op)
        OP_DEC: begin
          mag = word[31] ? (32'd0 - word) : word;
          do begin
            text.push_front(ASCII_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
          end while (mag != 0);
          if (word[31]) text.push_front(ASCII_MINUS);
        end
        OP_BIN: begin
          width = (pad_width > WORD_BITS) ? WORD_BITS : pad_width;
          ndig = sig_bits(word);
          if (width > ndig) ndig = width;
          if (ndig > 32) ndig = 32;
          text.push_back(ASCII_ZERO);
          text.push_back(ASCII_B);
          for (int i = ndig - 1; i >= 0; i--) text.push_back(ASCII_ZERO + 8'(word[i]));
        end
        OP_HEX: begin
          case (pad_width)
            6'd8:    width = 2;
            6'd16:   width = 4;
            6'd32:   width = 8;
            default: width = (WORD_BITS + 3) / 4;
          endcase
          ndig = (sig_bits(word) + 3) / 4;
          if (width > ndig) ndig = width;
          if (ndig > 8) ndig = 8;
          text.push_back(ASCII_ZERO);
          text.push_back(ASCII_X);
          for (int i = ndig - 1; i >= 0; i--) begin
            nib = 4'(word >> (4 * i));
            text.push_back(nib >= 4'd10 ? ASCII_ALPHA + 8'(nib) : ASCII_ZERO + 8'(nib));
          end
        end
        default: ;
      endcase
      foreach (text[i]) begin
        ch.item = item_count;
        ch.code = text[i];
        ch.last = (i == text.size() - 1);
        pending_chars.push_back(ch);
      end
      item_count++;
    endfunction

    task check_char(logic [7:0] code, logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected char 0x%02h last=%0b", code, last));
      end else begin
        want = pending_chars.pop_front();
        if (code !== want.code)
          report($sformatf("item %0d char 0x%02h, want 0x%02h", want.item, code, want.code));
        if (last !== want.last)
          report($sformatf("item %0d last %0b, want %0b", want.item, last, want.last));
      end
    endtask

    function int unsigned pending();
      return pending_chars.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata = '0;   // op[1:0], value[33:2], pad_width[39:34]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;        // char_code[7:0]
  logic                m_tlast;

  char_scoreboard sb = new();

  int unsigned burst_left = 0;
  rx_mode_t    rx_mode = RX_FREE;
  int unsigned rx_phase_left = 0;
  int unsigned rx_hold = 0;

  int_to_ascii_radix_format_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // receiver stall pattern, with a style drawn at random for each phase
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_phase_left <= $urandom_range(50, 400);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_BURSTY: begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) rx_hold <= $urandom_range(1, 20);
        end
        default:   m_tready <= rx_phase_left[0];
      endcase
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_char(m_tdata, m_tlast);
  end

  // one input transfer, then possibly a gap at the end of each burst
  task send_item(logic [1:0] op, logic [31:0] word, logic [5:0] pad_width);
    s_tvalid <= 1'b1;
    s_tdata  <= {pad_width, word, op};
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, word, pad_width);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // hold off the sender until every expected character has arrived
  task drain_outputs();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function logic [31:0] pick_value();
    int unsigned k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 20);
      2: return 32'd0 - $urandom_range(1, 20);
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h7FFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      4: return ($urandom_range(0, 1) != 0) ? ($urandom >> k) : ~($urandom >> k);
      default: begin
        case ($urandom_range(0, 2))
          0: return 32'd1 << k;
          1: return (32'd1 << k) - 32'd1;
          default: return 32'd0 - (32'd1 << k);
        endcase
      end
    endcase
  endfunction

  function logic [5:0] pick_pad();
    case ($urandom_range(0, 9))
      0, 1:    return 6'd8;
      2:       return 6'd16;
      3, 4:    return 6'd32;
      5, 6, 7: return 6'($urandom_range(0, 32));
      default: return 6'($urandom_range(33, 63));
    endcase
  endfunction

  // stimulus and end of run
  initial begin
    logic [1:0] op;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero, most negative, clamps, every radix
    send_item(OP_DEC,  32'd0,          6'd0);
    send_item(OP_DEC,  32'h8000_0000,  6'd0);
    send_item(OP_DEC,  32'h7FFF_FFFF,  6'd63);
    send_item(OP_DEC,  32'hFFFF_FFFF,  6'd32);
    send_item(OP_DEC,  32'd7,          6'd1);
    send_item(OP_BIN,  32'd0,          6'd0);
    send_item(OP_BIN,  32'd0,          6'd32);
    send_item(OP_BIN,  32'hFFFF_FFFF,  6'd0);
    send_item(OP_BIN,  32'd5,          6'd63);
    send_item(OP_BIN,  32'h8000_0000,  6'd1);
    send_item(OP_BIN,  32'h7FFF_FFFF,  6'd8);
    send_item(OP_BIN,  32'hFFFF_FFF0,  6'd8);
    send_item(OP_HEX,  32'd0,          6'd8);
    send_item(OP_HEX,  32'h0000_00AB,  6'd8);
    send_item(OP_HEX,  32'h0000_1234,  6'd16);
    send_item(OP_HEX,  32'hFFFF_FFFF,  6'd8);
    send_item(OP_HEX,  32'hFFFF_FF80,  6'd8);
    send_item(OP_HEX,  32'd0,          6'd0);
    send_item(OP_HEX,  32'h0001_2345,  6'd16);
    send_item(OP_HEX,  32'h8000_0000,  6'd32);
    send_item(OP_HEX,  32'hDEAD_BEEF,  6'd63);
    send_item(OP_NONE, 32'h1234_5678,  6'd8);
    send_item(OP_NONE, 32'hFFFF_FFFF,  6'd63);
    send_item(OP_DEC,  32'd1000000000, 6'd0);
    drain_outputs();

    // random items, with one full drain midway
    for (int n = 0; n < 200; n++) begin
      op = ($urandom_range(0, 15) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
      send_item(op, pick_value(), pick_pad());
      if (n == 100) drain_outputs();
    end

    drain_outputs();
    repeat (40) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("[int_to_ascii_radix_format_top] OK");
    end else begin
      $display("[int_to_ascii_radix_format_top] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("[int_to_ascii_radix_format_top] ERROR");
    $finish;
  end

endmodule
